/* sv/x86_64_mov_ret_encoder_top_assert.svh */
// Assertion macros used by the encoder's checker file.
`ifndef X86_64_MOV_RET_ENCODER_TOP_ASSERT_SVH
`define X86_64_MOV_RET_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define XMRE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("encoder check failed");

// Next-cycle implication, disabled while reset is high.
`define XMRE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("encoder check failed");

`endif

/* sv/xmre_pkg.sv */
// Types and constants of the MOV/RET encoder.
`default_nettype none
package xmre_pkg;

  localparam int SLOTS  = 13;
  localparam int SLOT_W = 4;

  // Byte slots of an encoded instruction, in emission order.
  localparam logic [SLOT_W-1:0] SLOT_P67   = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_P66   = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_REXW  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_OPC   = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_MODRM = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_DISP0 = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_DISP1 = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_DISP2 = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_DISP3 = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_IMM0  = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_IMM1  = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_IMM2  = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_IMM3  = 4'd12;

  localparam logic [7:0] BYTE_RET     = 8'hC3;
  localparam logic [7:0] BYTE_MOV_R8  = 8'h88;
  localparam logic [7:0] BYTE_MOV_R   = 8'h89;
  localparam logic [7:0] BYTE_MOV_I8  = 8'hC6;
  localparam logic [7:0] BYTE_MOV_I   = 8'hC7;
  localparam logic [7:0] BYTE_REXW    = 8'h48;
  localparam logic [7:0] BYTE_ADDR32  = 8'h67;
  localparam logic [7:0] BYTE_DATA16  = 8'h66;

  localparam logic       CMD_RET = 1'b0;
  localparam logic       CMD_MOV = 1'b1;

  localparam logic [1:0] DK_REG = 2'd0;
  localparam logic [1:0] DK_PTR = 2'd1;
  localparam logic [1:0] DK_SYM = 2'd2;

  localparam logic       SK_REG = 1'b0;
  localparam logic       SK_IMM = 1'b1;

  localparam logic [2:0] W_8  = 3'd1;
  localparam logic [2:0] W_16 = 3'd2;
  localparam logic [2:0] W_32 = 3'd3;
  localparam logic [2:0] W_64 = 3'd4;

  localparam logic [2:0] REG_SP = 3'd4;
  localparam logic [2:0] REG_BP = 3'd5;

  localparam logic [1:0] MOD_IND    = 2'd0;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SIZE     = 2'd1;
  localparam logic [1:0] ST_MEMSIZE  = 2'd2;
  localparam logic [1:0] ST_OPERANDS = 2'd3;

  typedef struct packed {
    logic               command;
    logic [1:0]         dest_kind;
    logic [2:0]         dest_reg;
    logic [2:0]         dest_size;
    logic               src_kind;
    logic [2:0]         src_reg;
    logic [2:0]         src_size;
    logic [2:0]         mem_size;
    logic signed [31:0] displacement;
    logic [31:0]        immediate;
  } cmd_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last;
    logic       reloc_start;
    logic [1:0] status;
  } code_t;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    logic [1:0]       status;
    logic             reloc;
    logic [7:0]       opc;
    logic [7:0]       modrm;
    logic [31:0]      disp;
    logic [31:0]      imm;
  } desc_t;

endpackage
`default_nettype wire

/* sv/xmre_front.sv */
// Front end: accepts instruction words and turns them into byte-slot descriptors.
`default_nettype none
module xmre_front (
  input  wire logic           valid,
  output logic                stall,
  input  wire xmre_pkg::cmd_t cmd,
  input  wire logic           full,
  output logic                push,
  output xmre_pkg::desc_t     desc
);
  import xmre_pkg::*;

  logic       err;
  logic [1:0] err_code;
  logic [2:0] data;
  logic [1:0] mod;
  logic [2:0] rm;
  logic [2:0] regf;
  logic       use_disp;
  logic       sym;

  function automatic logic width_ok(input logic [2:0] code);
    return (code >= W_8) && (code <= W_64);
  endfunction

  assign stall = full;
  assign push  = valid && !full;

  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    data     = cmd.dest_size;
    if (cmd.dest_kind == 2'd3) begin
      err      = 1'b1;
      err_code = ST_OPERANDS;
    end else if (cmd.dest_kind == DK_REG && cmd.src_kind == SK_REG) begin
      data = cmd.dest_size;
      if (cmd.dest_size != cmd.src_size || !width_ok(cmd.dest_size)) begin
        err      = 1'b1;
        err_code = ST_SIZE;
      end
    end else if (cmd.src_kind == SK_REG) begin
      data = cmd.src_size;
      if (!width_ok(cmd.src_size)) begin
        err      = 1'b1;
        err_code = ST_SIZE;
      end
    end else if (cmd.dest_kind == DK_REG) begin
      data = cmd.dest_size;
      if (!width_ok(cmd.dest_size)) begin
        err      = 1'b1;
        err_code = ST_SIZE;
      end
    end else begin
      data = cmd.mem_size;
      if (!width_ok(cmd.mem_size)) begin
        err      = 1'b1;
        err_code = ST_MEMSIZE;
      end
    end
    if (!err && cmd.dest_kind == DK_PTR && cmd.dest_reg == REG_SP) begin
      err      = 1'b1;
      err_code = ST_OPERANDS;
    end
  end

  always_comb begin
    regf     = (cmd.src_kind == SK_IMM) ? 3'd0 : cmd.src_reg;
    rm       = cmd.dest_reg;
    mod      = MOD_REG;
    use_disp = 1'b0;
    sym      = 1'b0;
    unique case (cmd.dest_kind)
      DK_REG: begin
        mod = MOD_REG;
      end
      DK_PTR: begin
        if (cmd.displacement != 32'sd0 || cmd.dest_reg == REG_BP) begin
          mod      = MOD_DISP32;
          use_disp = 1'b1;
        end else begin
          mod = MOD_IND;
        end
      end
      default: begin
        mod      = MOD_IND;
        rm       = REG_BP;
        use_disp = 1'b1;
        sym      = 1'b1;
      end
    endcase
  end

  always_comb begin
    desc        = '0;
    desc.disp   = sym ? 32'd0 : cmd.displacement;
    desc.imm    = cmd.immediate;
    desc.modrm  = {mod, regf, rm};
    desc.reloc  = sym;
    desc.status = ST_OK;
    if (cmd.command == CMD_RET) begin
      desc.mask[SLOT_OPC] = 1'b1;
      desc.opc            = BYTE_RET;
      desc.reloc          = 1'b0;
    end else if (err) begin
      desc.mask[SLOT_OPC] = 1'b1;
      desc.opc            = 8'd0;
      desc.status         = err_code;
      desc.reloc          = 1'b0;
    end else begin
      if (cmd.src_kind == SK_IMM) begin
        desc.opc = (data == W_8) ? BYTE_MOV_I8 : BYTE_MOV_I;
      end else begin
        desc.opc = (data == W_8) ? BYTE_MOV_R8 : BYTE_MOV_R;
      end
      desc.mask[SLOT_P67]   = (cmd.dest_kind == DK_PTR) && (cmd.dest_size == W_32);
      desc.mask[SLOT_P66]   = (data == W_16);
      desc.mask[SLOT_REXW]  = (data == W_64);
      desc.mask[SLOT_OPC]   = 1'b1;
      desc.mask[SLOT_MODRM] = 1'b1;
      desc.mask[SLOT_DISP0] = use_disp;
      desc.mask[SLOT_DISP1] = use_disp;
      desc.mask[SLOT_DISP2] = use_disp;
      desc.mask[SLOT_DISP3] = use_disp;
      desc.mask[SLOT_IMM0]  = (cmd.src_kind == SK_IMM);
      desc.mask[SLOT_IMM1]  = (cmd.src_kind == SK_IMM) && (data >= W_16);
      desc.mask[SLOT_IMM2]  = (cmd.src_kind == SK_IMM) && (data >= W_32);
      desc.mask[SLOT_IMM3]  = (cmd.src_kind == SK_IMM) && (data >= W_32);
    end
  end

endmodule
`default_nettype wire

/* sv/xmre_queue.sv */
// Short descriptor queue between the front end and the byte emitter.
`default_nettype none
module xmre_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire xmre_pkg::desc_t push_desc,
  output logic                 full,
  input  wire logic            pop,
  output logic                 nonempty,
  output xmre_pkg::desc_t      head
);
  import xmre_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  desc_t            slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/xmre_back.sv */
// Back end: walks a descriptor's byte slots and drives the registered byte output.
`default_nettype none
module xmre_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_nonempty,
  input  wire xmre_pkg::desc_t q_head,
  output logic                 q_pop,
  output logic                 valid,
  input  wire logic            stall,
  output xmre_pkg::code_t      code
);
  import xmre_pkg::*;

  desc_t             cur;
  logic [SLOTS-1:0]  rem;
  logic [SLOTS-1:0]  rem_next;
  logic              cur_valid;
  logic [SLOT_W-1:0] idx;
  logic [7:0]        sel_byte;
  logic              adv;
  logic              emit;
  logic              is_last;

  always_comb begin
    idx = SLOT_OPC;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) begin
        idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    unique case (idx)
      SLOT_P67:   sel_byte = BYTE_ADDR32;
      SLOT_P66:   sel_byte = BYTE_DATA16;
      SLOT_REXW:  sel_byte = BYTE_REXW;
      SLOT_OPC:   sel_byte = cur.opc;
      SLOT_MODRM: sel_byte = cur.modrm;
      SLOT_DISP0: sel_byte = cur.disp[7:0];
      SLOT_DISP1: sel_byte = cur.disp[15:8];
      SLOT_DISP2: sel_byte = cur.disp[23:16];
      SLOT_DISP3: sel_byte = cur.disp[31:24];
      SLOT_IMM0:  sel_byte = cur.imm[7:0];
      SLOT_IMM1:  sel_byte = cur.imm[15:8];
      SLOT_IMM2:  sel_byte = cur.imm[23:16];
      SLOT_IMM3:  sel_byte = cur.imm[31:24];
      default:    sel_byte = 8'd0;
    endcase
  end

  assign rem_next = rem & ~(SLOTS'(1) << idx);
  assign is_last  = (rem_next == '0);
  assign adv      = !valid || !stall;
  assign emit     = adv && cur_valid;
  assign q_pop    = q_nonempty && (!cur_valid || (emit && is_last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
      rem <= q_head.mask;
    end else if (emit) begin
      rem <= rem_next;
    end
    if (emit) begin
      code.byte_value  <= sel_byte;
      code.last        <= is_last;
      code.reloc_start <= cur.reloc && (idx == SLOT_DISP0);
      code.status      <= cur.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (emit && is_last) begin
        cur_valid <= 1'b0;
      end
      if (adv) begin
        valid <= emit;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/x86_64_mov_ret_encoder_top.sv */
// Top level of the x86-64 MOV/RET encoder.
//
//   channel  direction  handshake            word
//   cmd      in         cmd_valid/cmd_stall   cmd_t: one described instruction
//   code     out        code_valid/code_stall code_t: one machine code byte
//
// An instruction gives one to twelve bytes, one per cycle from the back end
// while the code channel is not stalled.
// The back end fetches the next descriptor in the cycle its last byte is registered.
// The front end stalls only when the QUEUE_DEPTH entry queue is full.
// The code channel holds its word while stalled; reset empties the queue and
// clears both valid flags.
`default_nettype none
module x86_64_mov_ret_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_stall,
  input  wire xmre_pkg::cmd_t  cmd,
  output logic                 code_valid,
  input  wire logic            code_stall,
  output xmre_pkg::code_t      code
);
  import xmre_pkg::*;

  desc_t front_desc;
  desc_t q_head;
  logic  push;
  logic  full;
  logic  pop;
  logic  nonempty;

  xmre_front u_front (
    .valid (cmd_valid),
    .stall (cmd_stall),
    .cmd   (cmd),
    .full  (full),
    .push  (push),
    .desc  (front_desc)
  );

  xmre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (front_desc),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (q_head)
  );

  xmre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (nonempty),
    .q_head     (q_head),
    .q_pop      (pop),
    .valid      (code_valid),
    .stall      (code_stall),
    .code       (code)
  );

endmodule
`default_nettype wire

/* sv/xmre_check.sv */
// Port-level checker of the encoder and its bind to the top level.
`default_nettype none
`include "x86_64_mov_ret_encoder_top_assert.svh"
module xmre_check (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_valid,
  input wire logic           cmd_stall,
  input wire xmre_pkg::cmd_t cmd,
  input wire logic           code_valid,
  input wire logic           code_stall,
  input wire xmre_pkg::code_t code
);
  import xmre_pkg::*;

  `XMRE_ASSERT_NXT(a_hold, clk, rst, code_valid && code_stall, code_valid && $stable(code))
  `XMRE_ASSERT_IMP(a_err_single, clk, rst, code_valid && code.status != ST_OK,
                   code.last && code.byte_value == 8'd0 && !code.reloc_start)
  `XMRE_ASSERT_IMP(a_reloc_mid, clk, rst, code_valid && code.reloc_start,
                   !code.last && code.status == ST_OK && code.byte_value == 8'd0)
  `XMRE_ASSERT_NXT(a_rst_clear, clk, 1'b0, rst, !code_valid && !cmd_stall)

endmodule

bind x86_64_mov_ret_encoder_top xmre_check u_check (.*);
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the x86-64 MOV/RET encoder: directed and random instructions.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import xmre_pkg::*;

  localparam logic [1:0] DK_BAD    = 2'd3;
  localparam logic [2:0] RM_RIP    = 3'd5;
  localparam int         IDLE_LIMIT = 1000;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         PRINT_LIMIT = 200;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cmd_valid = 1'b0;
  logic  cmd_stall;
  cmd_t  cmd = '0;
  logic  code_valid;
  logic  code_stall = 1'b0;
  code_t code;

  code_t want_queue[$];
  int    mismatch_count = 0;
  int    idle_cycles = 0;
  int    burst_left = 0;

  x86_64_mov_ret_encoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int width_of(input logic [2:0] wcode);
    case (wcode)
      W_8:     return 8;
      W_16:    return 16;
      W_32:    return 32;
      W_64:    return 64;
      default: return 0;
    endcase
  endfunction

  function automatic void predict_encoding(input cmd_t c);
    logic [7:0]  seq[SLOTS];
    logic [1:0]  err;
    logic [1:0]  md;
    logic [2:0]  rm;
    logic [2:0]  regf;
    logic [31:0] disp;
    logic        use_disp;
    logic        sym;
    int          data_w;
    int          n;
    int          nimm;
    int          reloc_at;
    code_t       b;
    err = ST_OK;
    n = 0;
    reloc_at = -1;
    data_w = 0;
    if (c.command == CMD_RET) begin
      seq[0] = BYTE_RET;
      n = 1;
    end else if (c.dest_kind == DK_BAD) begin
      err = ST_OPERANDS;
    end else begin
      if (c.dest_kind == DK_REG && c.src_kind == SK_REG) begin
        data_w = width_of(c.dest_size);
        if (data_w != width_of(c.src_size) || data_w == 0) err = ST_SIZE;
      end else if (c.src_kind == SK_REG) begin
        data_w = width_of(c.src_size);
        if (data_w == 0) err = ST_SIZE;
      end else if (c.dest_kind == DK_REG) begin
        data_w = width_of(c.dest_size);
        if (data_w == 0) err = ST_SIZE;
      end else begin
        data_w = width_of(c.mem_size);
        if (data_w == 0) err = ST_MEMSIZE;
      end
      if (err == ST_OK && c.dest_kind == DK_PTR && c.dest_reg == REG_SP) err = ST_OPERANDS;
      if (err == ST_OK) begin
        disp = c.displacement;
        use_disp = 1'b0;
        sym = 1'b0;
        regf = (c.src_kind == SK_IMM) ? 3'd0 : c.src_reg;
        if (c.dest_kind == DK_REG) begin
          md = MOD_REG;
          rm = c.dest_reg;
        end else if (c.dest_kind == DK_PTR) begin
          rm = c.dest_reg;
          if (disp != 32'd0 || c.dest_reg == REG_BP) begin
            md = MOD_DISP32;
            use_disp = 1'b1;
          end else begin
            md = MOD_IND;
          end
        end else begin
          md = MOD_IND;
          rm = RM_RIP;
          disp = 32'd0;
          use_disp = 1'b1;
          sym = 1'b1;
        end
        if (c.dest_kind == DK_PTR && c.dest_size == W_32) begin
          seq[n] = BYTE_ADDR32;
          n++;
        end
        if (data_w == 16) begin
          seq[n] = BYTE_DATA16;
          n++;
        end
        if (data_w == 64) begin
          seq[n] = BYTE_REXW;
          n++;
        end
        if (c.src_kind == SK_IMM) seq[n] = (data_w == 8) ? BYTE_MOV_I8 : BYTE_MOV_I;
        else seq[n] = (data_w == 8) ? BYTE_MOV_R8 : BYTE_MOV_R;
        n++;
        seq[n] = {md, regf, rm};
        n++;
        if (use_disp) begin
          if (sym) reloc_at = n;
          for (int i = 0; i < 4; i++) begin
            seq[n] = disp[8*i +: 8];
            n++;
          end
        end
        if (c.src_kind == SK_IMM) begin
          nimm = (data_w == 8) ? 1 : ((data_w == 16) ? 2 : 4);
          for (int i = 0; i < nimm; i++) begin
            seq[n] = c.immediate[8*i +: 8];
            n++;
          end
        end
      end
    end
    if (err != ST_OK) begin
      b.byte_value = 8'd0;
      b.last = 1'b1;
      b.reloc_start = 1'b0;
      b.status = err;
      want_queue.push_back(b);
    end else begin
      for (int k = 0; k < n; k++) begin
        b.byte_value = seq[k];
        b.last = (k == n - 1);
        b.reloc_start = (k == reloc_at);
        b.status = ST_OK;
        want_queue.push_back(b);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_word(input code_t got);
    code_t want;
    if (want_queue.size() == 0) begin
      report_mismatch("unexpected word", 32'(got), 32'd0);
    end else begin
      want = want_queue.pop_front();
      if (got.byte_value !== want.byte_value)
        report_mismatch("byte_value", 32'(got.byte_value), 32'(want.byte_value));
      if (got.last !== want.last)
        report_mismatch("last", 32'(got.last), 32'(want.last));
      if (got.reloc_start !== want.reloc_start)
        report_mismatch("reloc_start", 32'(got.reloc_start), 32'(want.reloc_start));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_stall === 1'b0) predict_encoding(cmd);
      if (code_valid === 1'b1 && !code_stall) check_word(code);
      if ((cmd_valid && cmd_stall === 1'b0) || (code_valid === 1'b1 && !code_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  logic [7:0] stall_pattern = 8'h00;
  int         stall_left = 0;
  int         stall_phase = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 96);
      stall_pattern = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 254));
    end
    code_stall <= stall_pattern[stall_phase % 8];
    stall_phase++;
    stall_left--;
  end

  task automatic send_instruction(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        cmd_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall !== 1'b0);
  endtask

  function automatic cmd_t make_mov(input logic [1:0] dk, input logic [2:0] dreg,
                                    input logic [2:0] dsize, input logic sk,
                                    input logic [2:0] sreg, input logic [2:0] ssize,
                                    input logic [2:0] msize, input logic [31:0] disp,
                                    input logic [31:0] imm);
    cmd_t c;
    c.command = CMD_MOV;
    c.dest_kind = dk;
    c.dest_reg = dreg;
    c.dest_size = dsize;
    c.src_kind = sk;
    c.src_reg = sreg;
    c.src_size = ssize;
    c.mem_size = msize;
    c.displacement = disp;
    c.immediate = imm;
    return c;
  endfunction

  function automatic logic [2:0] random_width();
    if ($urandom_range(0, 9) != 0) return 3'($urandom_range(1, 4));
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic cmd_t random_instruction();
    cmd_t c;
    c.command = ($urandom_range(0, 15) == 0) ? CMD_RET : CMD_MOV;
    c.dest_kind = ($urandom_range(0, 19) == 0) ? DK_BAD : 2'($urandom_range(0, 2));
    c.dest_reg = 3'($urandom_range(0, 7));
    c.dest_size = random_width();
    c.src_kind = 1'($urandom_range(0, 1));
    c.src_reg = 3'($urandom_range(0, 7));
    c.src_size = ($urandom_range(0, 3) == 0) ? random_width() : c.dest_size;
    c.mem_size = random_width();
    case ($urandom_range(0, 3))
      0:       c.displacement = 32'd0;
      1:       c.displacement = 32'($urandom_range(0, 255)) - 32'd128;
      default: c.displacement = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0:       c.immediate = 32'($urandom_range(0, 255));
      1:       c.immediate = 32'hFFFF_FFFF;
      default: c.immediate = $urandom;
    endcase
    return c;
  endfunction

  task automatic test_return();
    cmd_t c;
    c = '1;
    c.command = CMD_RET;
    send_instruction(c);
    c = '0;
    send_instruction(c);
  endtask

  task automatic test_register_moves();
    send_instruction(make_mov(DK_REG, 3'd0, W_8, SK_REG, 3'd7, W_8, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_REG, 3'd2, W_16, SK_REG, 3'd5, W_16, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_REG, 3'd6, W_32, SK_REG, 3'd1, W_32, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_REG, 3'd7, W_64, SK_REG, 3'd0, W_64, 3'd7, '1, '1));
  endtask

  task automatic test_immediate_moves();
    send_instruction(make_mov(DK_REG, 3'd1, W_8, SK_IMM, 3'd7, 3'd0, 3'd0, 32'd0, '1));
    send_instruction(make_mov(DK_REG, 3'd3, W_16, SK_IMM, 3'd0, 3'd0, 3'd0, 32'd0, 32'h1234_BEEF));
    send_instruction(make_mov(DK_REG, 3'd4, W_32, SK_IMM, 3'd0, 3'd7, 3'd0, 32'd0, 32'hDEAD_0001));
    send_instruction(make_mov(DK_REG, 3'd5, W_64, SK_IMM, 3'd0, 3'd0, 3'd0, 32'd0, 32'h8000_0001));
    send_instruction(make_mov(DK_PTR, 3'd7, W_64, SK_IMM, 3'd0, 3'd0, W_64, 32'd4, 32'h7F));
  endtask

  task automatic test_pointer_moves();
    send_instruction(make_mov(DK_PTR, 3'd3, W_64, SK_REG, 3'd2, W_64, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_PTR, 3'd0, W_32, SK_REG, 3'd6, W_16, 3'd0, 32'h7FFF_FFFF, 32'd0));
    send_instruction(make_mov(DK_PTR, REG_BP, W_64, SK_REG, 3'd1, W_8, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_PTR, 3'd6, W_16, SK_IMM, 3'd0, 3'd0, W_8, 32'h8000_0000, 32'hA5));
  endtask

  task automatic test_symbol_moves();
    send_instruction(make_mov(DK_SYM, 3'd2, W_64, SK_REG, 3'd3, W_32, 3'd0, 32'h0000_1234, 32'd0));
    send_instruction(make_mov(DK_SYM, 3'd0, 3'd0, SK_IMM, 3'd0, 3'd0, W_16, 32'd0, 32'hCAFE));
  endtask

  task automatic test_errors();
    send_instruction(make_mov(DK_REG, 3'd0, W_32, SK_REG, 3'd1, W_64, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_REG, 3'd0, 3'd7, SK_REG, 3'd1, 3'd7, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_REG, 3'd2, 3'd5, SK_IMM, 3'd0, 3'd0, 3'd0, 32'd0, 32'd1));
    send_instruction(make_mov(DK_PTR, 3'd1, W_64, SK_REG, 3'd1, 3'd0, 3'd0, 32'd8, 32'd0));
    send_instruction(make_mov(DK_PTR, 3'd1, W_64, SK_IMM, 3'd0, 3'd0, 3'd0, 32'd8, 32'd5));
    send_instruction(make_mov(DK_SYM, 3'd1, W_64, SK_IMM, 3'd0, 3'd0, 3'd6, 32'd0, 32'd5));
    send_instruction(make_mov(DK_PTR, REG_SP, W_64, SK_REG, 3'd0, W_64, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_PTR, REG_SP, W_64, SK_IMM, 3'd0, 3'd0, 3'd0, 32'd0, 32'd0));
    send_instruction(make_mov(DK_BAD, 3'd0, W_64, SK_REG, 3'd0, W_64, W_64, 32'd0, 32'd0));
  endtask

  task automatic test_random_stream();
    repeat (434) send_instruction(random_instruction());
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_return();
    test_register_moves();
    test_immediate_moves();
    test_pointer_moves();
    test_symbol_moves();
    test_errors();
    test_random_stream();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (want_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/xmre_pkg.sv
sv/xmre_front.sv
sv/xmre_queue.sv
sv/xmre_back.sv
sv/x86_64_mov_ret_encoder_top.sv
sv/xmre_check.sv
tb/testbench.sv
